/* hdl/pcal_pkg.sv */
// shared types, constants and codes for the piecewise-linear calibration block
`timescale 1ns / 1ps
package pcal_pkg;

    // table size and sample width
    localparam int SAMPLE_BITS = 12;
    localparam int MAX_POINTS  = 64;
    localparam int INDEX_BITS  = 6;
    localparam int CFG_BITS    = 7;

    // reset value of the points-in-use register
    localparam logic [CFG_BITS-1:0] PIU_RESET = 7'd33;

    // request modes
    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

    // range flag codes
    localparam logic [1:0] FLAG_INTERP = 2'd0;
    localparam logic [1:0] FLAG_BELOW  = 2'd1;
    localparam logic [1:0] FLAG_ABOVE  = 2'd2;

    // one request
    typedef struct packed {
        logic                   mode;
        logic [INDEX_BITS-1:0]  point_index;
        logic [SAMPLE_BITS-1:0] point_from_mv;
        logic [SAMPLE_BITS-1:0] point_to_mv;
        logic [SAMPLE_BITS-1:0] sample_mv;
    } t_req;

    // one result
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] calibrated_mv;
        logic [1:0]             range_flag;
    } t_res;

    // one breakpoint pair as stored in the table
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] from_mv;
        logic [SAMPLE_BITS-1:0] to_mv;
    } t_entry;

endpackage

/* hdl/piecewise_linear_calibration.sv */
// top level: request decode, segment search sequencer and result register
`timescale 1ns / 1ps
// Piecewise-linear calibration over a table of up to MAX_POINTS breakpoint pairs,
// in millivolts. A request with mode 0 stores one pair and leaves busy low; a
// request with mode 1 converts one sample. The table is one synchronous memory
// read once per cycle, so a conversion walks it entry by entry: it checks the
// first point, then the last point, then each segment in turn, and for a sample
// inside a segment it multiplies and then runs the bit-serial divider. Busy
// stays high until the result is shown, and a new request is taken in the cycle
// the result appears. The result is on o_res for exactly one cycle with o_valid
// high; the receiver cannot stall it. Table entries read by a conversion must be
// written first; the user must write the points-in-use register only while busy
// is low, which the block itself does not enforce.
module piecewise_linear_calibration #(
    parameter int MAX_POINTS = pcal_pkg::MAX_POINTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  pcal_pkg::t_req                 i_req,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic [pcal_pkg::CFG_BITS-1:0]  i_cfg_data,
    output logic                           o_valid,
    output pcal_pkg::t_res                 o_res
);
    import pcal_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int W  = SAMPLE_BITS;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIRST = 3'd1;
    localparam logic [2:0] ST_LAST  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_WAIT  = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [CFG_BITS-1:0] r_cfg;
    logic                r_valid, n_valid;
    t_res                r_res, n_res;
    logic [W-1:0]        r_sample, n_sample;
    logic [W-1:0]        r_x1, n_x1;
    logic [W-1:0]        r_y1, n_y1;
    logic [W-1:0]        r_yl, n_yl;
    logic [AW-1:0]       r_idx, n_idx;
    logic [W-1:0]        r_dv, n_dv;
    logic [W-1:0]        r_dx, n_dx;
    logic [W-1:0]        r_dy, n_dy;
    logic                r_neg, n_neg;
    logic [2*W-1:0]      r_prod;

    logic                w_accept;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    t_entry              w_wdata;
    logic [AW-1:0]       w_raddr;
    t_entry              w_rdata;
    logic [AW-1:0]       w_last;
    logic                w_div_start;
    logic                w_div_done;
    logic [W-1:0]        w_quo;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    // table write for a store request, slots beyond the table are dropped
    assign w_we    = w_accept && (i_req.mode == MODE_WRITE)
                     && (32'(i_req.point_index) < 32'(MAX_POINTS));
    assign w_waddr = AW'(i_req.point_index);
    assign w_wdata = '{from_mv: i_req.point_from_mv, to_mv: i_req.point_to_mv};

    // index of the last point in use, count saturated to 2..MAX_POINTS
    always_comb begin
        if (r_cfg < CFG_BITS'(2)) begin
            w_last = AW'(1);
        end else if (32'(r_cfg) > 32'(MAX_POINTS)) begin
            w_last = AW'(MAX_POINTS - 1);
        end else begin
            w_last = AW'(32'(r_cfg) - 32'd1);
        end
    end

    // read address for the entry needed in the next state
    always_comb begin
        case (r_state)
            ST_IDLE:  w_raddr = '0;
            ST_FIRST: w_raddr = w_last;
            ST_LAST:  w_raddr = AW'(1);
            ST_SCAN:  w_raddr = r_idx + AW'(1);
            default:  w_raddr = '0;
        endcase
    end

    pcal_table #(
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_div_start = (r_state == ST_DIV);

    pcal_div #(
        .W (W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_dx),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // sequencer: clamp checks, segment walk, multiply, divide
    always_comb begin
        n_state  = r_state;
        n_valid  = 1'b0;
        n_res    = r_res;
        n_sample = r_sample;
        n_x1     = r_x1;
        n_y1     = r_y1;
        n_yl     = r_yl;
        n_idx    = r_idx;
        n_dv     = r_dv;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_neg    = r_neg;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_req.mode == MODE_CONVERT)) begin
                    n_sample = i_req.sample_mv;
                    n_state  = ST_FIRST;
                end
            end
            ST_FIRST: begin
                // first entry, also the left end of segment 0
                n_x1 = w_rdata.from_mv;
                n_y1 = w_rdata.to_mv;
                if (r_sample <= w_rdata.from_mv) begin
                    n_res   = '{calibrated_mv: w_rdata.to_mv, range_flag: FLAG_BELOW};
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_yl = w_rdata.to_mv;
                if (r_sample >= w_rdata.from_mv) begin
                    n_res   = '{calibrated_mv: w_rdata.to_mv, range_flag: FLAG_ABOVE};
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = AW'(1);
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read data is the right end of the segment under test
                if ((r_sample >= r_x1) && (r_sample <= w_rdata.from_mv)) begin
                    if (w_rdata.from_mv == r_x1) begin
                        n_res   = '{calibrated_mv: r_y1, range_flag: FLAG_INTERP};
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_dv    = r_sample - r_x1;
                        n_dx    = w_rdata.from_mv - r_x1;
                        n_neg   = (w_rdata.to_mv < r_y1);
                        n_dy    = (w_rdata.to_mv < r_y1) ? (r_y1 - w_rdata.to_mv)
                                                         : (w_rdata.to_mv - r_y1);
                        n_state = ST_MUL;
                    end
                end else if (r_idx == w_last) begin
                    // no enclosing segment
                    n_res   = '{calibrated_mv: r_yl, range_flag: FLAG_ABOVE};
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_x1  = w_rdata.from_mv;
                    n_y1  = w_rdata.to_mv;
                    n_idx = r_idx + AW'(1);
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                // quotient is at most the step height, so the sum stays in range
                if (w_div_done) begin
                    n_res   = '{calibrated_mv: r_neg ? (r_y1 - w_quo) : (r_y1 + w_quo),
                                range_flag: FLAG_INTERP};
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state and configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_cfg   <= PIU_RESET;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // datapath registers, product registered ahead of the divider
    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_sample <= n_sample;
        r_x1     <= n_x1;
        r_y1     <= n_y1;
        r_yl     <= n_yl;
        r_idx    <= n_idx;
        r_dv     <= n_dv;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_neg    <= n_neg;
        r_prod   <= r_dv * r_dy;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* hdl/pcal_table.sv */
// breakpoint table: one write port, one registered read port
`timescale 1ns / 1ps
module pcal_table #(
    parameter int DEPTH = pcal_pkg::MAX_POINTS
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  pcal_pkg::t_entry           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output pcal_pkg::t_entry           o_rdata
);
    import pcal_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // synchronous write and read, read data registered and shown in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/pcal_div.sv */
// restoring divider, one quotient bit per cycle, quotient known to fit W bits
`timescale 1ns / 1ps
module pcal_div #(
    parameter int W = pcal_pkg::SAMPLE_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2*W-1:0] i_dividend,
    input  logic [W-1:0]   i_divisor,
    output logic           o_done,
    output logic [W-1:0]   o_quotient
);
    import pcal_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_lo, n_lo;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_div, n_div;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_run, n_run;
    logic          r_done, n_done;
    logic [W:0]    w_trial;
    logic          w_fits;

    // shift in the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_lo[W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_quo  = r_quo;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_start) begin
            // high half is already below the divisor
            n_rem = i_dividend[2*W-1:W];
            n_lo  = i_dividend[W-1:0];
            n_div = i_divisor;
            n_quo = '0;
            n_cnt = CW'(W);
            n_run = 1'b1;
        end else if (r_run) begin
            n_rem = w_fits ? W'(w_trial - {1'b0, r_div}) : w_trial[W-1:0];
            n_lo  = {r_lo[W-2:0], 1'b0};
            n_quo = {r_quo[W-2:0], w_fits};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_lo  <= n_lo;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hdl/pcal_checker.sv */
// port-level checks of the calibration block, bound to the top level
`timescale 1ns / 1ps
module pcal_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  pcal_pkg::t_req                 i_req,
    input  logic                           busy,
    input  logic                           i_cfg_we,
    input  logic [pcal_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic                           o_valid,
    input  pcal_pkg::t_res                 o_res
);
    import pcal_pkg::*;

    // a result always closes a conversion that held busy
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a conversion in progress");

    // a store request gives no result and no busy time
    a_store_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.mode == MODE_WRITE)) |=> (!busy && !o_valid))
        else $error("store request raised busy or a result");

    // a conversion request holds the block busy
    a_convert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.mode == MODE_CONVERT)) |=> busy)
        else $error("conversion request did not raise busy");

    // one request gives at most one result strobe
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // flag codes stay within the defined set
    a_flag_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_res.range_flag == FLAG_INTERP) || (o_res.range_flag == FLAG_BELOW)
                     || (o_res.range_flag == FLAG_ABOVE)))
        else $error("undefined range flag");

endmodule

bind piecewise_linear_calibration pcal_checker u_pcal_checker (.*);
